>>> hdl/rsp_pkg.sv
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared widths, register codes, lane tag and matrix helpers for the
// rotated stereographic projection pipeline.
// ----------------------------------------------------------------------------
package rsp_pkg;

    localparam int MAT_W = 48;   // one packed matrix row
    localparam int ENT_W = 16;   // one Q2.14 matrix entry
    localparam int NRM_W = 16;   // Q2.14 normal component
    localparam int PNT_W = 22;   // Q8.14 detector coordinate
    localparam int NUM_W = 66;   // divider dividend
    localparam int DEN_W = 44;   // divider divisor
    localparam int Q_W   = 24;   // quotient bits, top ones only flag overflow
    localparam int SUM_W = 46;   // signed numerator before the divider

    localparam logic [MAT_W-1:0] ROW0_RESET = 48'h4000_0000_0000;
    localparam logic [MAT_W-1:0] ROW1_RESET = 48'h0000_4000_0000;
    localparam logic [MAT_W-1:0] ROW2_RESET = 48'h0000_0000_4000;

    typedef enum logic [1:0] {
        REG_ROW0 = 2'd0,
        REG_ROW1 = 2'd1,
        REG_ROW2 = 2'd2
    } rsp_reg_t;

    typedef struct packed {
        logic       mode;
        logic       invalid;
        logic [2:0] neg;
    } rsp_tag_t;

    typedef logic [2:0][MAT_W-1:0] rsp_matrix_t;

    function automatic logic signed [ENT_W-1:0] mat_entry(input logic [MAT_W-1:0] row,
                                                          input logic [1:0] col);
        logic signed [ENT_W-1:0] e;
        case (col)
            2'd0:    e = $signed(row[47:32]);
            2'd1:    e = $signed(row[31:16]);
            default: e = $signed(row[15:0]);
        endcase
        return e;
    endfunction

endpackage

>>> hdl/rotated_stereographic_projection_unit.sv
// ----------------------------------------------------------------------------
// rotated_stereographic_projection_unit
// Rotates a unit normal and projects it onto the detector plane (mode 0), or
// maps a detector point back to a rotated normal (mode 1).
//
// Input channel: in_valid / in_stall, one request per cycle, fields mode,
// in_nx..in_nz (forward) and in_px, in_py (inverse). Output channel:
// out_valid / out_stall, one result per request, in order.
// The pipe has three set-up stages, 24 divider stages (one quotient bit each,
// three lanes) and three stages of clamping, matrix product and rounding. It
// takes one request per cycle while out_stall is low.
// When the receiver stalls a held result, the whole pipe freezes and
// in_stall rises in the same cycle; nothing is dropped or repeated.
// Configuration: cfg_valid / cfg_ready (always ready) writes matrix rows 0 to
// 2 by cfg_index; other indexes are ignored. Rows may only change while the
// pipe holds no request. Reset empties the pipe and loads the identity.
// ----------------------------------------------------------------------------
module rotated_stereographic_projection_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 mode,
    input  logic signed [rsp_pkg::NRM_W-1:0]     in_nx,
    input  logic signed [rsp_pkg::NRM_W-1:0]     in_ny,
    input  logic signed [rsp_pkg::NRM_W-1:0]     in_nz,
    input  logic signed [rsp_pkg::PNT_W-1:0]     in_px,
    input  logic signed [rsp_pkg::PNT_W-1:0]     in_py,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic signed [rsp_pkg::PNT_W-1:0]     out_px,
    output logic signed [rsp_pkg::PNT_W-1:0]     out_py,
    output logic signed [rsp_pkg::NRM_W-1:0]     out_nx,
    output logic signed [rsp_pkg::NRM_W-1:0]     out_ny,
    output logic signed [rsp_pkg::NRM_W-1:0]     out_nz,
    output logic                                 invalid,
    output logic                                 saturated,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [1:0]                           cfg_index,
    input  logic [rsp_pkg::MAT_W-1:0]            cfg_data
);

    logic                               en;
    rsp_pkg::rsp_matrix_t               matrix_reg;
    logic                               f_valid, d_valid;
    logic [2:0][rsp_pkg::NUM_W-1:0]     f_num;
    logic [rsp_pkg::DEN_W-1:0]          f_den;
    rsp_pkg::rsp_tag_t                  f_tag, d_tag;
    logic [2:0][rsp_pkg::Q_W-1:0]       d_q;

    // the pipe advances unless a finished result is held
    assign en        = ~(out_valid & out_stall);
    assign in_stall  = ~en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_reg[0] <= rsp_pkg::ROW0_RESET;
            matrix_reg[1] <= rsp_pkg::ROW1_RESET;
            matrix_reg[2] <= rsp_pkg::ROW2_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                rsp_pkg::REG_ROW0: matrix_reg[0] <= cfg_data;
                rsp_pkg::REG_ROW1: matrix_reg[1] <= cfg_data;
                rsp_pkg::REG_ROW2: matrix_reg[2] <= cfg_data;
                default:           ;
            endcase
        end
    end

    rsp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .mode     (mode),
        .in_nx    (in_nx),
        .in_ny    (in_ny),
        .in_nz    (in_nz),
        .in_px    (in_px),
        .in_py    (in_py),
        .matrix   (matrix_reg),
        .f_valid  (f_valid),
        .f_num    (f_num),
        .f_den    (f_den),
        .f_tag    (f_tag)
    );

    rsp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_num    (f_num),
        .in_den    (f_den),
        .in_tag    (f_tag),
        .out_valid (d_valid),
        .out_q     (d_q),
        .out_tag   (d_tag)
    );

    rsp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (d_valid),
        .in_q      (d_q),
        .in_tag    (d_tag),
        .matrix    (matrix_reg),
        .out_valid (out_valid),
        .out_px    (out_px),
        .out_py    (out_py),
        .out_nx    (out_nx),
        .out_ny    (out_ny),
        .out_nz    (out_nz),
        .invalid   (invalid),
        .saturated (saturated)
    );

    // a flagged point is zeroed and never counts as clamped
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && invalid |-> out_px == '0 && out_py == '0 && !saturated)
        else $error("invalid result carries a point");

    // forward and inverse fields never both carry data
    a_mode_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_px != '0 || out_py != '0 || invalid)
        |-> out_nx == '0 && out_ny == '0 && out_nz == '0)
        else $error("result mixes both modes");

    // recovered normals stay inside the clamp range
    a_normal_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_nx >= -16'sd16384 && out_nx <= 16'sd16384
                   && out_ny >= -16'sd16384 && out_ny <= 16'sd16384
                   && out_nz >= -16'sd16384 && out_nz <= 16'sd16384)
        else $error("normal outside clamp range");

endmodule

>>> hdl/rsp_front.sv
// ----------------------------------------------------------------------------
// rsp_front
// Products, sums and dividend set-up for both modes, three register stages.
// ----------------------------------------------------------------------------
module rsp_front (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      en,
    input  logic                                      in_valid,
    input  logic                                      mode,
    input  logic signed [rsp_pkg::NRM_W-1:0]          in_nx,
    input  logic signed [rsp_pkg::NRM_W-1:0]          in_ny,
    input  logic signed [rsp_pkg::NRM_W-1:0]          in_nz,
    input  logic signed [rsp_pkg::PNT_W-1:0]          in_px,
    input  logic signed [rsp_pkg::PNT_W-1:0]          in_py,
    input  rsp_pkg::rsp_matrix_t                      matrix,
    output logic                                      f_valid,
    output logic [2:0][rsp_pkg::NUM_W-1:0]            f_num,
    output logic [rsp_pkg::DEN_W-1:0]                 f_den,
    output rsp_pkg::rsp_tag_t                         f_tag
);

    localparam logic signed [34:0] ONE_S  = 35'sd268435456;
    localparam logic signed [34:0] S_MIN  = 35'sd16384;

    // stage a: products
    logic                      vld_a_reg;
    logic                      mode_a_reg;
    logic signed [31:0]        prod_a_reg [9];
    logic signed [31:0]        prod_a_next [9];
    logic signed [43:0]        xx_a_reg, yy_a_reg, xx_a_next, yy_a_next;
    logic signed [rsp_pkg::PNT_W-1:0] px_a_reg, py_a_reg;
    logic signed [rsp_pkg::NRM_W-1:0] n_vec [3];

    // stage b: sums
    logic                      vld_b_reg, mode_b_reg, inv_b_reg, inv_b_next;
    logic signed [rsp_pkg::SUM_W-1:0] num_b_reg [3];
    logic signed [rsp_pkg::SUM_W-1:0] num_b_next [3];
    logic [rsp_pkg::DEN_W-1:0] den_b_reg, den_b_next;
    logic signed [33:0]        v_sum [3];
    logic signed [34:0]        s_val;
    logic [43:0]               r2;

    // stage c: dividend
    logic                      vld_c_reg;
    logic [2:0][rsp_pkg::NUM_W-1:0] num_c_reg, num_c_next;
    logic [rsp_pkg::DEN_W-1:0] den_c_reg;
    rsp_pkg::rsp_tag_t         tag_c_reg, tag_c_next;
    logic [rsp_pkg::SUM_W-1:0] mag [3];

    assign n_vec[0] = in_nx;
    assign n_vec[1] = in_ny;
    assign n_vec[2] = in_nz;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_a_next[i*3+j] = rsp_pkg::mat_entry(matrix[i], 2'(j)) * n_vec[j];
            end
        end
        xx_a_next = in_px * in_px;
        yy_a_next = in_py * in_py;
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            v_sum[i] = prod_a_reg[i*3] + prod_a_reg[i*3+1] + prod_a_reg[i*3+2];
        end
        s_val = ONE_S + v_sum[0];
        r2    = 44'(xx_a_reg) + 44'(yy_a_reg);
        if (!mode_a_reg)
        begin
            num_b_next[0] = 46'(v_sum[1]);
            num_b_next[1] = 46'(v_sum[2]);
            num_b_next[2] = '0;
            den_b_next    = 44'(s_val);
            inv_b_next    = s_val < S_MIN;
        end
        else
        begin
            num_b_next[0] = 46'sd268435456 - $signed({2'b00, r2});
            num_b_next[1] = {{9{px_a_reg[21]}}, px_a_reg, 15'd0};
            num_b_next[2] = {{9{py_a_reg[21]}}, py_a_reg, 15'd0};
            den_b_next    = r2 + 44'd268435456;
            inv_b_next    = 1'b0;
        end
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            mag[l] = num_b_reg[l][rsp_pkg::SUM_W-1] ? 46'(-num_b_reg[l]) : num_b_reg[l];
            if (mode_b_reg)
                num_c_next[l] = ({20'd0, mag[l]} << 20) + {22'd0, den_b_reg >> 1};
            else
                num_c_next[l] = ({20'd0, mag[l]} << 14) + {22'd0, den_b_reg >> 1};
            tag_c_next.neg[l] = num_b_reg[l][rsp_pkg::SUM_W-1];
        end
        tag_c_next.mode    = mode_b_reg;
        tag_c_next.invalid = inv_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_a_reg <= in_valid;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode_a_reg <= mode;
            prod_a_reg <= prod_a_next;
            xx_a_reg   <= xx_a_next;
            yy_a_reg   <= yy_a_next;
            px_a_reg   <= in_px;
            py_a_reg   <= in_py;
            mode_b_reg <= mode_a_reg;
            inv_b_reg  <= inv_b_next;
            num_b_reg  <= num_b_next;
            den_b_reg  <= den_b_next;
            num_c_reg  <= num_c_next;
            den_c_reg  <= den_b_reg;
            tag_c_reg  <= tag_c_next;
        end
    end

    assign f_valid = vld_c_reg;
    assign f_num   = num_c_reg;
    assign f_den   = den_c_reg;
    assign f_tag   = tag_c_reg;

endmodule

>>> hdl/rsp_div.sv
// ----------------------------------------------------------------------------
// rsp_div
// Three-lane restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module rsp_div (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [2:0][rsp_pkg::NUM_W-1:0]       in_num,
    input  logic [rsp_pkg::DEN_W-1:0]            in_den,
    input  rsp_pkg::rsp_tag_t                    in_tag,
    output logic                                 out_valid,
    output logic [2:0][rsp_pkg::Q_W-1:0]         out_q,
    output rsp_pkg::rsp_tag_t                    out_tag
);

    localparam int NQ = rsp_pkg::Q_W;

    logic                               st_vld [NQ+1];
    logic [2:0][rsp_pkg::NUM_W-1:0]     st_rem [NQ+1];
    logic [2:0][NQ-1:0]                 st_q   [NQ+1];
    logic [rsp_pkg::DEN_W-1:0]          st_den [NQ+1];
    rsp_pkg::rsp_tag_t                  st_tag [NQ+1];

    assign st_vld[0] = in_valid;
    assign st_rem[0] = in_num;
    assign st_q[0]   = '0;
    assign st_den[0] = in_den;
    assign st_tag[0] = in_tag;

    for (genvar s = 0; s < NQ; s++)
    begin : g_stage
        localparam int K = NQ - 1 - s;

        logic                           vld_reg;
        logic [2:0][rsp_pkg::NUM_W-1:0] rem_reg, rem_next;
        logic [2:0][NQ-1:0]             q_reg, q_next;
        logic [rsp_pkg::DEN_W-1:0]      den_reg;
        rsp_pkg::rsp_tag_t              tag_reg;
        logic [rsp_pkg::NUM_W:0]        den_sh;
        logic [rsp_pkg::NUM_W:0]        rem_ext [3];
        logic [rsp_pkg::NUM_W:0]        diff [3];

        always_comb
        begin
            den_sh = {{(rsp_pkg::NUM_W + 1 - rsp_pkg::DEN_W){1'b0}}, st_den[s]} << K;
            for (int l = 0; l < 3; l++)
            begin
                rem_ext[l] = {1'b0, st_rem[s][l]};
                diff[l]    = rem_ext[l] - den_sh;
                q_next[l]  = st_q[s][l];
                if (rem_ext[l] >= den_sh)
                begin
                    rem_next[l]  = diff[l][rsp_pkg::NUM_W-1:0];
                    q_next[l][K] = 1'b1;
                end
                else
                begin
                    rem_next[l] = st_rem[s][l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg <= 1'b0;
            else if (en)
                vld_reg <= st_vld[s];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg <= rem_next;
                q_reg   <= q_next;
                den_reg <= st_den[s];
                tag_reg <= st_tag[s];
            end
        end

        assign st_vld[s+1] = vld_reg;
        assign st_rem[s+1] = rem_reg;
        assign st_q[s+1]   = q_reg;
        assign st_den[s+1] = den_reg;
        assign st_tag[s+1] = tag_reg;
    end

    assign out_valid = st_vld[NQ];
    assign out_q     = st_q[NQ];
    assign out_tag   = st_tag[NQ];

endmodule

>>> hdl/rsp_back.sv
// ----------------------------------------------------------------------------
// rsp_back
// Quotient signing and clamping, transposed matrix product, rounding and
// the output register.
// ----------------------------------------------------------------------------
module rsp_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [2:0][rsp_pkg::Q_W-1:0]         in_q,
    input  rsp_pkg::rsp_tag_t                    in_tag,
    input  rsp_pkg::rsp_matrix_t                 matrix,
    output logic                                 out_valid,
    output logic signed [rsp_pkg::PNT_W-1:0]     out_px,
    output logic signed [rsp_pkg::PNT_W-1:0]     out_py,
    output logic signed [rsp_pkg::NRM_W-1:0]     out_nx,
    output logic signed [rsp_pkg::NRM_W-1:0]     out_ny,
    output logic signed [rsp_pkg::NRM_W-1:0]     out_nz,
    output logic                                 invalid,
    output logic                                 saturated
);

    localparam logic [rsp_pkg::Q_W-1:0] P_POS_LIM = 24'd2097151;
    localparam logic [rsp_pkg::Q_W-1:0] P_NEG_LIM = 24'd2097152;
    localparam logic [19:0]             N_LIM     = 20'd16384;

    // stage d
    logic vld_d_reg, mode_d_reg, inv_d_reg, sat_d_reg, sat_d_next;
    logic signed [rsp_pkg::PNT_W-1:0] p_d_reg [2];
    logic signed [rsp_pkg::PNT_W-1:0] p_d_next [2];
    logic signed [rsp_pkg::PNT_W-1:0] w_d_reg [3];
    logic signed [rsp_pkg::PNT_W-1:0] w_d_next [3];

    // stage e
    logic vld_e_reg, mode_e_reg, inv_e_reg, sat_e_reg;
    logic signed [rsp_pkg::PNT_W-1:0] p_e_reg [2];
    logic signed [37:0] prod_e_reg [9];
    logic signed [37:0] prod_e_next [9];

    // stage f, output register
    logic vld_f_reg, inv_f_reg, sat_f_reg, sat_f_next;
    logic signed [rsp_pkg::PNT_W-1:0] p_f_reg [2];
    logic signed [rsp_pkg::PNT_W-1:0] p_f_next [2];
    logic signed [rsp_pkg::NRM_W-1:0] n_f_reg [3];
    logic signed [rsp_pkg::NRM_W-1:0] n_f_next [3];
    logic signed [39:0] acc [3];
    logic [39:0]        acc_mag [3];
    logic [39:0]        acc_rnd [3];
    logic [19:0]        r_mag [3];
    logic [15:0]        r_cl [3];

    always_comb
    begin
        sat_d_next = 1'b0;
        for (int l = 0; l < 2; l++)
        begin
            if (in_tag.invalid || in_tag.mode)
            begin
                p_d_next[l] = '0;
            end
            else if (!in_tag.neg[l])
            begin
                if (in_q[l] > P_POS_LIM)
                begin
                    p_d_next[l] = 22'sd2097151;
                    sat_d_next  = 1'b1;
                end
                else
                begin
                    p_d_next[l] = in_q[l][rsp_pkg::PNT_W-1:0];
                end
            end
            else
            begin
                if (in_q[l] > P_NEG_LIM)
                begin
                    p_d_next[l] = 22'h200000;
                    sat_d_next  = 1'b1;
                end
                else
                begin
                    p_d_next[l] = 22'(24'd0 - in_q[l]);
                end
            end
        end
        for (int l = 0; l < 3; l++)
        begin
            w_d_next[l] = in_tag.neg[l] ? 22'(24'd0 - in_q[l]) : in_q[l][rsp_pkg::PNT_W-1:0];
        end
    end

    // column i of the matrix against the inverse vector
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_e_next[i*3+j] = rsp_pkg::mat_entry(matrix[j], 2'(i)) * w_d_reg[j];
            end
        end
    end

    always_comb
    begin
        sat_f_next = mode_e_reg ? 1'b0 : sat_e_reg;
        for (int i = 0; i < 3; i++)
        begin
            acc[i]     = prod_e_reg[i*3] + prod_e_reg[i*3+1] + prod_e_reg[i*3+2];
            acc_mag[i] = acc[i][39] ? 40'(-acc[i]) : acc[i];
            acc_rnd[i] = acc_mag[i] + 40'd524288;
            r_mag[i]   = acc_rnd[i][39:20];
            if (r_mag[i] > N_LIM)
            begin
                r_cl[i] = N_LIM[15:0];
                if (mode_e_reg)
                    sat_f_next = 1'b1;
            end
            else
            begin
                r_cl[i] = r_mag[i][15:0];
            end
            if (!mode_e_reg)
                n_f_next[i] = '0;
            else
                n_f_next[i] = acc[i][39] ? 16'(16'd0 - r_cl[i]) : r_cl[i];
        end
        for (int l = 0; l < 2; l++)
        begin
            p_f_next[l] = mode_e_reg ? '0 : p_e_reg[l];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_d_reg <= 1'b0;
            vld_e_reg <= 1'b0;
            vld_f_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_d_reg <= in_valid;
            vld_e_reg <= vld_d_reg;
            vld_f_reg <= vld_e_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mode_d_reg <= in_tag.mode;
            inv_d_reg  <= in_tag.invalid & ~in_tag.mode;
            sat_d_reg  <= sat_d_next;
            p_d_reg    <= p_d_next;
            w_d_reg    <= w_d_next;
            mode_e_reg <= mode_d_reg;
            inv_e_reg  <= inv_d_reg;
            sat_e_reg  <= sat_d_reg;
            p_e_reg    <= p_d_reg;
            prod_e_reg <= prod_e_next;
            inv_f_reg  <= inv_e_reg;
            sat_f_reg  <= sat_f_next;
            p_f_reg    <= p_f_next;
            n_f_reg    <= n_f_next;
        end
    end

    assign out_valid = vld_f_reg;
    assign out_px    = p_f_reg[0];
    assign out_py    = p_f_reg[1];
    assign out_nx    = n_f_reg[0];
    assign out_ny    = n_f_reg[1];
    assign out_nz    = n_f_reg[2];
    assign invalid   = inv_f_reg;
    assign saturated = sat_f_reg;

endmodule
